### sv/flm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the queue lock manager.
// Depends on nothing; every other file of the block imports it.
package flm_pkg;

   localparam int ID_W     = 4;
   localparam int ID_COUNT = 1 << ID_W;
   localparam int STATUS_W = 3;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_GRANTED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_QUEUED      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REL_IDLE    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REL_HANDOFF = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ERROR       = 3'd4;

   typedef struct packed {
      logic            opcode;
      logic [ID_W-1:0] requester_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                grant_valid;
      logic [ID_W-1:0]     grant_id;
   } result_type;

endpackage

### sv/flm_req_if.sv
`timescale 1ns / 1ps
// Request channel of the queue lock manager: valid, ready and one request item.
// Depends on flm_pkg.
interface flm_req_if import flm_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            opcode;
   logic [ID_W-1:0] requester_id;

   modport source (output valid, output opcode, output requester_id, input ready);
   modport sink (input valid, input opcode, input requester_id, output ready);
endinterface

### sv/flm_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the queue lock manager: valid, ready and one result item.
// Depends on flm_pkg.
interface flm_rsp_if import flm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                grant_valid;
   logic [ID_W-1:0]     grant_id;

   modport source (output valid, output status, output grant_valid, output grant_id,
                   input ready);
   modport sink (input valid, input status, input grant_valid, input grant_id,
                 output ready);
endinterface

### sv/flm_lock_table.sv
`timescale 1ns / 1ps
// Lock state of the queue lock manager: tail, holder, successor links and queue marks.
// Computes the result of one request and commits the new state on step_en. Uses flm_pkg.
module flm_lock_table import flm_pkg::*; #(
   parameter int NUM_AGENTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  req_type    item,
   output result_type result
);

   localparam int DEPTH = (NUM_AGENTS < ID_COUNT) ? NUM_AGENTS : ID_COUNT;
   localparam int IDX_W = $clog2(DEPTH);

   logic             tail_valid_ff, tail_valid_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0] holder_ff, holder_in;
   logic [DEPTH-1:0] succ_valid_ff, succ_valid_in;
   logic [DEPTH-1:0] in_queue_ff, in_queue_in;
   logic [IDX_W-1:0] succ_agent_ff [DEPTH];
   logic [IDX_W-1:0] succ_agent_in [DEPTH];

   logic             in_range;
   logic [IDX_W-1:0] idx;

   assign in_range = 32'(item.requester_id) < NUM_AGENTS;
   assign idx      = item.requester_id[IDX_W-1:0];

   always_comb begin
      tail_valid_in = tail_valid_ff;
      tail_in       = tail_ff;
      holder_in     = holder_ff;
      succ_valid_in = succ_valid_ff;
      in_queue_in   = in_queue_ff;
      succ_agent_in = succ_agent_ff;
      result        = '{status: ST_ERROR, grant_valid: 1'b0, grant_id: '0};
      if (in_range) begin
         if (item.opcode == OP_ACQUIRE) begin
            if (!in_queue_ff[idx]) begin
               in_queue_in[idx]   = 1'b1;
               succ_valid_in[idx] = 1'b0;
               tail_in            = idx;
               if (!tail_valid_ff) begin
                  tail_valid_in = 1'b1;
                  holder_in     = idx;
                  result        = '{status: ST_GRANTED, grant_valid: 1'b1,
                                    grant_id: ID_W'(idx)};
               end else begin
                  succ_valid_in[tail_ff] = 1'b1;
                  succ_agent_in[tail_ff] = idx;
                  result.status          = ST_QUEUED;
               end
            end
         end else if (tail_valid_ff && holder_ff == idx) begin
            in_queue_in[idx] = 1'b0;
            if (succ_valid_ff[idx]) begin
               succ_valid_in[idx] = 1'b0;
               holder_in          = succ_agent_ff[idx];
               result             = '{status: ST_REL_HANDOFF, grant_valid: 1'b1,
                                      grant_id: ID_W'(succ_agent_ff[idx])};
            end else begin
               tail_valid_in = 1'b0;
               result.status = ST_REL_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_valid_ff <= 1'b0;
         tail_ff       <= '0;
         holder_ff     <= '0;
         succ_valid_ff <= '0;
         in_queue_ff   <= '0;
      end else if (step_en) begin
         tail_valid_ff <= tail_valid_in;
         tail_ff       <= tail_in;
         holder_ff     <= holder_in;
         succ_valid_ff <= succ_valid_in;
         in_queue_ff   <= in_queue_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         succ_agent_ff <= succ_agent_in;
      end
   end

endmodule

### sv/fifo_queue_lock_manager.sv
`timescale 1ns / 1ps
// Top level of the queue lock manager: input register, lock state and result register.
// Depends on flm_pkg, flm_req_if, flm_rsp_if and flm_lock_table.
//
// Each request item on req_ch is an acquire or a release from one agent.
// Each request gives exactly one result item on rsp_ch: a status, and a grant
// flag with the agent that newly holds the lock.
// An acquire on an empty queue is granted at once; otherwise the agent waits
// behind the tail. A release from the holder passes the lock to the next agent
// in arrival order, or leaves the queue empty. Bad requests report an error
// and change nothing.
// A request is first taken into the input register; its result then goes to the
// result register. Throughput: one request per cycle while rsp_ch does not stall,
// since each request reads and writes only the tail, the holder and one link entry.
// When rsp_ch stalls, the result register holds its item and the input
// register holds one more request; req_ch.ready then drops.
// Synchronous reset empties the queue, clears all links and marks, and drops
// both registers; no clearing pass is needed.
module fifo_queue_lock_manager import flm_pkg::*; #(
   parameter int NUM_AGENTS = 16
) (
   input logic       clock,
   input logic       reset,
   flm_req_if.sink   req_ch,
   flm_rsp_if.source rsp_ch
);

   logic       in_valid_ff, in_valid_in;
   req_type    in_item_ff, in_item_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_item_ff, out_item_in;
   result_type step_result;
   logic       advance;
   logic       accept;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign in_item_in   = accept ? req_type'{opcode: req_ch.opcode,
                                            requester_id: req_ch.requester_id}
                                : in_item_ff;
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);
   assign out_item_in  = advance ? step_result : out_item_ff;

   flm_lock_table #(
      .NUM_AGENTS(NUM_AGENTS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.status      = out_item_ff.status;
   assign rsp_ch.grant_valid = out_item_ff.grant_valid;
   assign rsp_ch.grant_id    = out_item_ff.grant_id;

endmodule

### sv/flm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the queue lock manager, attached to the top level by bind.
// Depends on flm_pkg and fifo_queue_lock_manager.
module flm_checker import flm_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_grant_valid,
   input logic [ID_W-1:0]     rsp_grant_id
);

   // A pending result item stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item withdrawn before it was taken");

   // A grant is reported only by an immediate grant or a handoff, and both always grant.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_grant_valid ==
                     (rsp_status == ST_GRANTED || rsp_status == ST_REL_HANDOFF)))
      else $error("grant flag does not match status");

   // Results without a grant carry agent zero, and no status lies past the error code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_ERROR) && (rsp_grant_valid || rsp_grant_id == '0))
      else $error("malformed result item");

   // A result appears on an idle channel only for a request that was taken and has passed the input register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result item without a matching request");

endmodule

bind fifo_queue_lock_manager flm_checker u_flm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_grant_valid (rsp_ch.grant_valid),
   .rsp_grant_id    (rsp_ch.grant_id)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the queue lock manager: a lock queue tracker predicts each result.
// Depends on flm_pkg, flm_req_if, flm_rsp_if and the fifo_queue_lock_manager RTL.
module testbench;
   import flm_pkg::*;

   localparam int AGENT_COUNT = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 650;

   class lock_queue_tracker;
      bit                 tail_valid;
      logic [ID_W-1:0]    tail_agent;
      logic [ID_W-1:0]    holder_agent;
      bit                 link_valid [AGENT_COUNT];
      logic [ID_W-1:0]    link_agent [AGENT_COUNT];
      bit                 queued [AGENT_COUNT];
      int                 queue_len;
      result_type         expected_results [$];
      int                 failures;
      int                 grants_now, waits, handoffs, idle_releases, rejects, deepest;

      function new();
         tail_valid = 0;
         tail_agent = '0;
         holder_agent = '0;
         foreach (queued[i]) begin
            queued[i] = 0;
            link_valid[i] = 0;
            link_agent[i] = '0;
         end
         queue_len = 0;
         failures = 0;
         grants_now = 0;
         waits = 0;
         handoffs = 0;
         idle_releases = 0;
         rejects = 0;
         deepest = 0;
      endfunction

      function void note_request(logic op, logic [ID_W-1:0] id);
         result_type r;
         r.status = ST_ERROR;
         r.grant_valid = 1'b0;
         r.grant_id = '0;
         if (int'(id) >= AGENT_COUNT) begin
            rejects++;
         end else if (op == OP_ACQUIRE) begin
            if (queued[id]) begin
               rejects++;
            end else begin
               queued[id] = 1;
               link_valid[id] = 0;
               queue_len++;
               if (queue_len > deepest) deepest = queue_len;
               if (!tail_valid) begin
                  tail_valid = 1;
                  tail_agent = id;
                  holder_agent = id;
                  r.status = ST_GRANTED;
                  r.grant_valid = 1'b1;
                  r.grant_id = id;
                  grants_now++;
               end else begin
                  link_valid[tail_agent] = 1;
                  link_agent[tail_agent] = id;
                  tail_agent = id;
                  r.status = ST_QUEUED;
                  waits++;
               end
            end
         end else if (!tail_valid || holder_agent != id) begin
            rejects++;
         end else begin
            queued[id] = 0;
            queue_len--;
            if (link_valid[id]) begin
               link_valid[id] = 0;
               holder_agent = link_agent[id];
               r.status = ST_REL_HANDOFF;
               r.grant_valid = 1'b1;
               r.grant_id = link_agent[id];
               handoffs++;
            end else begin
               tail_valid = 0;
               r.status = ST_REL_IDLE;
               idle_releases++;
            end
         end
         expected_results.push_back(r);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            $error("result item with nothing expected: status %0d grant_valid %0d grant_id %0d",
                   got.status, got.grant_valid, got.grant_id);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failures++;
         end
         if (got.grant_valid !== want.grant_valid) begin
            $error("grant_valid: expected %0d, actual %0d", want.grant_valid, got.grant_valid);
            failures++;
         end
         if (got.grant_id !== want.grant_id) begin
            $error("grant_id: expected %0d, actual %0d", want.grant_id, got.grant_id);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   flm_req_if req_ch ();
   flm_rsp_if rsp_ch ();

   lock_queue_tracker tracker = new();
   int          cycle_count = 0;
   int          stall_left = 0;
   bit          rsp_burst = 0;
   result_type  got;

   fifo_queue_lock_manager #(.NUM_AGENTS(AGENT_COUNT)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fifo_queue_lock_manager: mismatch");
         $finish;
      end
   end

   // After each result item the receiver may stall at random; in burst phases it does not stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status = rsp_ch.status;
            got.grant_valid = rsp_ch.grant_valid;
            got.grant_id = rsp_ch.grant_id;
            tracker.check_result(got);
            if ($urandom_range(0, 24) == 0) rsp_burst = !rsp_burst;
            stall_left = rsp_burst ? 0 : $urandom_range(0, 7);
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_lock_request(input logic op, input logic [ID_W-1:0] id, input int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.requester_id <= id;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_request(op, id);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic            op;
      logic [ID_W-1:0] id;
      bit              send_burst;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_ACQUIRE;
      req_ch.requester_id = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Double acquires, releases from waiters and from an empty queue, and
      // re-acquiring after a release are all exercised here.
      send_lock_request(OP_ACQUIRE, 4'd0, $urandom_range(0, 7));
      send_lock_request(OP_ACQUIRE, 4'd15, $urandom_range(0, 7));
      send_lock_request(OP_ACQUIRE, 4'd0, $urandom_range(0, 7));
      send_lock_request(OP_ACQUIRE, 4'd15, $urandom_range(0, 7));
      send_lock_request(OP_RELEASE, 4'd15, $urandom_range(0, 7));
      send_lock_request(OP_ACQUIRE, 4'd7, 0);
      send_lock_request(OP_RELEASE, 4'd0, 0);
      send_lock_request(OP_RELEASE, 4'd15, 0);
      send_lock_request(OP_RELEASE, 4'd7, $urandom_range(0, 7));
      send_lock_request(OP_RELEASE, 4'd7, $urandom_range(0, 7));
      send_lock_request(OP_RELEASE, 4'd0, $urandom_range(0, 7));
      send_lock_request(OP_ACQUIRE, 4'd15, $urandom_range(0, 7));
      send_lock_request(OP_RELEASE, 4'd15, 0);
      send_lock_request(OP_ACQUIRE, 4'd0, 0);
      send_lock_request(OP_ACQUIRE, 4'd5, $urandom_range(0, 7));
      send_lock_request(OP_ACQUIRE, 4'd10, $urandom_range(0, 7));
      send_lock_request(OP_RELEASE, 4'd0, 0);
      send_lock_request(OP_ACQUIRE, 4'd0, 0);
      send_lock_request(OP_RELEASE, 4'd5, $urandom_range(0, 7));
      send_lock_request(OP_RELEASE, 4'd10, $urandom_range(0, 7));
      send_lock_request(OP_RELEASE, 4'd0, 0);
      drain_results();

      send_burst = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) drain_results();
         if ($urandom_range(0, 99) < 12) begin
            op = 1'($urandom_range(0, 1));
            id = ID_W'($urandom_range(0, 15));
         end else if (tracker.tail_valid && (tracker.queue_len >= AGENT_COUNT ||
                      $urandom_range(0, AGENT_COUNT) < tracker.queue_len)) begin
            op = OP_RELEASE;
            id = tracker.holder_agent;
         end else begin
            op = OP_ACQUIRE;
            do id = ID_W'($urandom_range(0, AGENT_COUNT - 1)); while (tracker.queued[id]);
         end
         send_lock_request(op, id, send_burst ? 0 : $urandom_range(0, 7));
      end
      drain_results();
      repeat (8) @(posedge clock);

      $display("Ran %0d lock requests: %0d immediate grants, %0d waits,",
               tracker.grants_now + tracker.waits + tracker.handoffs + tracker.idle_releases
               + tracker.rejects, tracker.grants_now, tracker.waits);
      $display("%0d handoffs and %0d idle releases; %0d were rejected, longest queue %0d.",
               tracker.handoffs, tracker.idle_releases, tracker.rejects, tracker.deepest);
      if (tracker.failures == 0 && tracker.expected_results.size() == 0) begin
         $display("fifo_queue_lock_manager: match");
      end else begin
         $display("fifo_queue_lock_manager: mismatch");
      end
      $finish;
   end
endmodule

### fifo_queue_lock_manager.f
sv/flm_pkg.sv
sv/flm_req_if.sv
sv/flm_rsp_if.sv
sv/flm_lock_table.sv
sv/fifo_queue_lock_manager.sv
sv/flm_checker.sv
tb/testbench.sv
